// File: src/c2s_pkg.sv
// ----------------------------------------------------------------------------
// Shared types and constants for the 2x2 linear system solver
// Solution codes and the output width and fraction constants.
// ----------------------------------------------------------------------------
package c2s_pkg;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_UNIQUE   = 2'd1,
        KIND_INFINITE = 2'd2
    } kind_t;

    localparam int OUT_WIDTH = 32;
    localparam int OUT_FRAC  = 16;

endpackage

// File: src/c2s_div_cell.sv
// ----------------------------------------------------------------------------
// Divider chain cell
// One restoring division step for both quotients, with side data carried.
// ----------------------------------------------------------------------------
module c2s_div_cell #(
    parameter int DW = 66,
    parameter int QW = 50
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic          in_ready_down,
    input  logic [DW-1:0] in_den,
    input  logic [DW-1:0] in_rx,
    input  logic [DW-1:0] in_ry,
    input  logic [QW-1:0] in_qx,
    input  logic [QW-1:0] in_qy,
    input  logic [5:0]    in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_den,
    output logic [DW-1:0] out_rx,
    output logic [DW-1:0] out_ry,
    output logic [QW-1:0] out_qx,
    output logic [QW-1:0] out_qy,
    output logic [5:0]    out_side
);

    logic          valid_reg;
    logic [DW-1:0] den_reg, rx_reg, ry_reg;
    logic [QW-1:0] qx_reg, qy_reg;
    logic [5:0]    side_reg;
    logic [DW:0]   sx, sy;
    logic [DW-1:0] rx_next, ry_next;
    logic [QW-1:0] qx_next, qy_next;

    // Trial subtraction: remainder doubled in, take one quotient bit.
    always_comb begin
        sx = {in_rx, in_qx[QW-1]} - {1'b0, in_den};
        sy = {in_ry, in_qy[QW-1]} - {1'b0, in_den};
        rx_next = sx[DW] ? {in_rx[DW-2:0], in_qx[QW-1]} : sx[DW-1:0];
        ry_next = sy[DW] ? {in_ry[DW-2:0], in_qy[QW-1]} : sy[DW-1:0];
        qx_next = {in_qx[QW-2:0], ~sx[DW]};
        qy_next = {in_qy[QW-2:0], ~sy[DW]};
    end

    // Valid flag advances whenever the chain moves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready_down) begin
            valid_reg <= in_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_ready_down) begin
            den_reg  <= in_den;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_den   = den_reg;
    assign out_rx    = rx_reg;
    assign out_ry    = ry_reg;
    assign out_qx    = qx_reg;
    assign out_qy    = qy_reg;
    assign out_side  = side_reg;

endmodule

// File: src/cramer_2x2_solver.sv
// ----------------------------------------------------------------------------
// 2x2 linear system solver by Cramer's rule
// Pipelined solver: determinants, a chain of division cells, saturation.
// ----------------------------------------------------------------------------
// Usage: present the six coefficients on s_* with s_valid; a transaction is
// accepted when s_valid and s_ready are both high. Each transaction gives one
// result on m_*: solution_kind, x_value, y_value (signed Q16.16, truncated
// toward zero) and saturated.
// Throughput is one transaction per cycle while the output is not stalled. The
// pipeline has a multiply register, a subtract register, a magnitude register,
// one cell per quotient bit (2*COEF_WIDTH+18 cells, both quotients in the same
// cell) and one output register.
// The pipeline advances as one whole: when m_ready is low and a result waits,
// every stage holds and s_ready falls, so nothing is lost.
// Reset clears all valid flags; no transaction is in flight afterwards.
// ----------------------------------------------------------------------------
module cramer_2x2_solver #(
    parameter int COEF_WIDTH     = 16,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COEF_WIDTH-1:0] s_coef_a1,
    input  logic [COEF_WIDTH-1:0] s_coef_b1,
    input  logic [COEF_WIDTH-1:0] s_rhs_c1,
    input  logic [COEF_WIDTH-1:0] s_coef_a2,
    input  logic [COEF_WIDTH-1:0] s_coef_b2,
    input  logic [COEF_WIDTH-1:0] s_rhs_c2,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_solution_kind,
    output logic [31:0]           m_x_value,
    output logic [31:0]           m_y_value,
    output logic                  m_saturated
);

    // Product and determinant widths; fraction bits cancel in the ratio.
    localparam int PW = 2 * COEF_WIDTH;
    localparam int DW = PW + 2;
    localparam int QW = DW + c2s_pkg::OUT_FRAC;
    localparam int NC = QW;
    localparam int FRAC_UNUSED = COEF_FRAC_BITS;

    logic adv;

    // Stage 1: six products.
    logic              v1_reg;
    logic signed [PW-1:0] p_as_reg, p_ab_reg, p_cb2_reg, p_cb1_reg, p_ac2_reg, p_ac1_reg;
    // Stage 2: determinants.
    logic              v2_reg;
    logic signed [DW-1:0] d_reg, dx_reg, dy_reg;
    // Stage 3: magnitudes and flags.
    logic              v3_reg;
    logic [DW-1:0]     md_reg, mx_reg, my_reg;
    logic [5:0]        side3_reg;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Multipliers, one per product, registered.
    always_ff @(posedge aclk) begin
        if (adv) begin
            p_as_reg  <= $signed(s_coef_a1) * $signed(s_coef_b2);
            p_ab_reg  <= $signed(s_coef_a2) * $signed(s_coef_b1);
            p_cb2_reg <= $signed(s_rhs_c1)  * $signed(s_coef_b2);
            p_cb1_reg <= $signed(s_rhs_c2)  * $signed(s_coef_b1);
            p_ac2_reg <= $signed(s_coef_a1) * $signed(s_rhs_c2);
            p_ac1_reg <= $signed(s_coef_a2) * $signed(s_rhs_c1);
        end
    end

    // Differences of products.
    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg  <= DW'(p_as_reg)  - DW'(p_ab_reg);
            dx_reg <= DW'(p_cb2_reg) - DW'(p_cb1_reg);
            dy_reg <= DW'(p_ac2_reg) - DW'(p_ac1_reg);
        end
    end

    // Magnitudes; side bits: det zero, all zero, sign of x, sign of y.
    always_ff @(posedge aclk) begin
        if (adv) begin
            md_reg <= d_reg[DW-1]  ? DW'(-d_reg)  : DW'(d_reg);
            mx_reg <= dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
            my_reg <= dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
            side3_reg <= {2'b00,
                          d_reg == '0,
                          (d_reg == '0) && (dx_reg == '0) && (dy_reg == '0),
                          dx_reg[DW-1] ^ d_reg[DW-1],
                          dy_reg[DW-1] ^ d_reg[DW-1]};
        end
    end

    // Chain of division cells, numerator scaled by 2^16.
    logic          cv   [NC+1];
    logic [DW-1:0] cden [NC+1];
    logic [DW-1:0] crx  [NC+1];
    logic [DW-1:0] cry  [NC+1];
    logic [QW-1:0] cqx  [NC+1];
    logic [QW-1:0] cqy  [NC+1];
    logic [5:0]    cside[NC+1];

    assign cv[0]    = v3_reg;
    assign cden[0]  = md_reg;
    assign crx[0]   = '0;
    assign cry[0]   = '0;
    assign cqx[0]   = {mx_reg, {c2s_pkg::OUT_FRAC{1'b0}}};
    assign cqy[0]   = {my_reg, {c2s_pkg::OUT_FRAC{1'b0}}};
    assign cside[0] = side3_reg;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        c2s_div_cell #(.DW(DW), .QW(QW)) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .in_valid      (cv[g]),
            .in_ready_down (adv),
            .in_den        (cden[g]),
            .in_rx         (crx[g]),
            .in_ry         (cry[g]),
            .in_qx         (cqx[g]),
            .in_qy         (cqy[g]),
            .in_side       (cside[g]),
            .out_valid     (cv[g+1]),
            .out_den       (cden[g+1]),
            .out_rx        (crx[g+1]),
            .out_ry        (cry[g+1]),
            .out_qx        (cqx[g+1]),
            .out_qy        (cqy[g+1]),
            .out_side      (cside[g+1])
        );
    end

    // Saturate and sign the quotients.
    logic [QW-1:0] qx, qy;
    logic          sx_ovf, sy_ovf, negx, negy, dz, allz;
    logic [31:0]   xo, yo;
    c2s_pkg::kind_t kind;

    always_comb begin
        qx   = cqx[NC];
        qy   = cqy[NC];
        dz   = cside[NC][3];
        allz = cside[NC][2];
        negx = cside[NC][1];
        negy = cside[NC][0];
        sx_ovf = negx ? (qx > QW'(33'h080000000)) : (qx > QW'(33'h07FFFFFFF));
        sy_ovf = negy ? (qy > QW'(33'h080000000)) : (qy > QW'(33'h07FFFFFFF));
        xo = sx_ovf ? (negx ? 32'h80000000 : 32'h7FFFFFFF)
                    : (negx ? 32'(-qx) : qx[31:0]);
        yo = sy_ovf ? (negy ? 32'h80000000 : 32'h7FFFFFFF)
                    : (negy ? 32'(-qy) : qy[31:0]);
        if (allz) begin
            kind = c2s_pkg::KIND_INFINITE;
        end else if (!dz) begin
            kind = c2s_pkg::KIND_UNIQUE;
        end else begin
            kind = c2s_pkg::KIND_NONE;
        end
    end

    // Output register.
    logic        mv_reg;
    logic [1:0]  kind_reg;
    logic [31:0] x_reg, y_reg;
    logic        sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (adv) begin
            mv_reg <= cv[NC];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind_reg <= kind;
            x_reg    <= (kind == c2s_pkg::KIND_UNIQUE) ? xo : '0;
            y_reg    <= (kind == c2s_pkg::KIND_UNIQUE) ? yo : '0;
            sat_reg  <= (kind == c2s_pkg::KIND_UNIQUE) && (sx_ovf || sy_ovf)
                        && (FRAC_UNUSED >= 0);
        end
    end

    assign m_valid         = mv_reg;
    assign m_solution_kind = kind_reg;
    assign m_x_value       = x_reg;
    assign m_y_value       = y_reg;
    assign m_saturated     = sat_reg;

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_x_value) && $stable(m_y_value))
        else $error("result changed under stall");
    // Non-unique results carry zero values.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_solution_kind != c2s_pkg::KIND_UNIQUE |->
        m_x_value == '0 && m_y_value == '0 && !m_saturated)
        else $error("non-unique result not zero");
    // Input is refused only while the output stalls.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("pipeline stalled without back-pressure");

endmodule
